### design/smalu_pkg.sv
// ----------------------------------------------------------------------------
// smalu_pkg
// Shared constants, types and the control store of the stack arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package smalu_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OP_W        = 4;
  localparam int unsigned ST_W        = 2;
  localparam int unsigned DEPTH_OUT_W = 7;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned DIV_CNT_W   = $clog2(DATA_W);
  localparam int unsigned UA_W        = 4;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_CLEAR = 4'd0;
  localparam logic [OP_W-1:0] OP_PUSH  = 4'd1;
  localparam logic [OP_W-1:0] OP_POP   = 4'd2;
  localparam logic [OP_W-1:0] OP_ADD   = 4'd3;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd4;
  localparam logic [OP_W-1:0] OP_MUL   = 4'd5;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd6;
  localparam logic [OP_W-1:0] OP_MOD   = 4'd7;
  localparam logic [OP_W-1:0] OP_NOT   = 4'd8;
  localparam logic [OP_W-1:0] OP_GT    = 4'd9;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_UNDER = 2'd1;
  localparam logic [ST_W-1:0] ST_OVER  = 2'd2;
  localparam logic [ST_W-1:0] ST_DIVZ  = 2'd3;

  // Micro-actions, one per control word
  typedef enum logic [3:0] {
    ACT_CLEAR = 4'd0,
    ACT_CHK   = 4'd1,
    ACT_PUSH  = 4'd2,
    ACT_POP   = 4'd3,
    ACT_NOT   = 4'd4,
    ACT_DVI   = 4'd5,
    ACT_DVS   = 4'd6,
    ACT_WB    = 4'd7,
    ACT_FIN   = 4'd8
  } act_e;

  // Sequencing conditions
  typedef enum logic [2:0] {
    C_NEXT = 3'd0,  // advance
    C_GOTO = 3'd1,  // jump always
    C_ERR  = 3'd2,  // jump when the check failed
    C_NDIV = 3'd3,  // jump when the request is not a divide or modulo
    C_LOOP = 3'd4   // jump while the divider has steps left
  } cond_e;

  typedef struct packed {
    act_e            act;
    cond_e           cond;
    logic [UA_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic init;
    logic step;
  } div_ctrl_t;

  // Control store addresses
  localparam logic [UA_W-1:0] UA_CLEAR = 4'd0;
  localparam logic [UA_W-1:0] UA_PUSH  = 4'd1;
  localparam logic [UA_W-1:0] UA_POP   = 4'd3;
  localparam logic [UA_W-1:0] UA_NOT   = 4'd5;
  localparam logic [UA_W-1:0] UA_BIN   = 4'd7;
  localparam logic [UA_W-1:0] UA_DLOOP = 4'd9;
  localparam logic [UA_W-1:0] UA_WB    = 4'd10;
  localparam logic [UA_W-1:0] UA_FIN   = 4'd11;

  function automatic ucw_t ucode_rom(input logic [UA_W-1:0] addr);
    ucw_t w;
    w = '{act: ACT_FIN, cond: C_NEXT, target: UA_FIN};
    unique case (addr)
      4'd0:    w = '{act: ACT_CLEAR, cond: C_GOTO, target: UA_FIN};
      4'd1:    w = '{act: ACT_CHK,   cond: C_ERR,  target: UA_FIN};
      4'd2:    w = '{act: ACT_PUSH,  cond: C_GOTO, target: UA_FIN};
      4'd3:    w = '{act: ACT_CHK,   cond: C_ERR,  target: UA_FIN};
      4'd4:    w = '{act: ACT_POP,   cond: C_GOTO, target: UA_FIN};
      4'd5:    w = '{act: ACT_CHK,   cond: C_ERR,  target: UA_FIN};
      4'd6:    w = '{act: ACT_NOT,   cond: C_GOTO, target: UA_FIN};
      4'd7:    w = '{act: ACT_CHK,   cond: C_ERR,  target: UA_FIN};
      4'd8:    w = '{act: ACT_DVI,   cond: C_NDIV, target: UA_WB};
      4'd9:    w = '{act: ACT_DVS,   cond: C_LOOP, target: UA_DLOOP};
      4'd10:   w = '{act: ACT_WB,    cond: C_GOTO, target: UA_FIN};
      default: w = '{act: ACT_FIN,   cond: C_NEXT, target: UA_FIN};
    endcase
    return w;
  endfunction

  function automatic logic [UA_W-1:0] ucode_entry(input logic [OP_W-1:0] op);
    logic [UA_W-1:0] a;
    a = UA_FIN;
    case (op) inside
      OP_CLEAR:                                        a = UA_CLEAR;
      OP_PUSH:                                         a = UA_PUSH;
      OP_POP:                                          a = UA_POP;
      OP_NOT:                                          a = UA_NOT;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_GT:   a = UA_BIN;
      default:                                         a = UA_FIN;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### design/smalu_div.sv
// ----------------------------------------------------------------------------
// smalu_div
// Restoring signed divider, one quotient bit per step, C truncation rules.
// ----------------------------------------------------------------------------
`default_nettype none

module smalu_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  smalu_pkg::div_ctrl_t                ctrl_i,
  input  logic [smalu_pkg::DATA_W-1:0]        dividend_i,
  input  logic [smalu_pkg::DATA_W-1:0]        divisor_i,
  output logic [smalu_pkg::DATA_W-1:0]        quot_o,
  output logic [smalu_pkg::DATA_W-1:0]        rem_o,
  output logic                                last_o
);
  import smalu_pkg::*;

  logic [DATA_W-1:0]    quo_q, rem_q, den_q;
  logic                 qneg_q, rneg_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DATA_W:0]      rem_sh, diff;
  logic [DATA_W-1:0]    mag_a, mag_b;

  assign mag_a  = dividend_i[DATA_W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign mag_b  = divisor_i[DATA_W-1]  ? (~divisor_i + 1'b1)  : divisor_i;
  assign rem_sh = {rem_q, quo_q[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.init) begin
      cnt_q <= '0;
    end else if (ctrl_i.step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      quo_q  <= mag_a;
      rem_q  <= '0;
      den_q  <= mag_b;
      qneg_q <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
      rneg_q <= dividend_i[DATA_W-1];
    end else if (ctrl_i.step) begin
      // keep the partial remainder when the trial subtract goes negative
      if (!diff[DATA_W]) begin
        rem_q <= diff[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign last_o = (cnt_q == DIV_CNT_W'(DATA_W - 1));
  assign quot_o = qneg_q ? (~quo_q + 1'b1) : quo_q;
  assign rem_o  = rneg_q ? (~rem_q + 1'b1) : rem_q;

endmodule

`default_nettype wire

### design/stack_machine_alu_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_alu_unit
// Bounded 32-bit integer stack driven by stack-language requests, with a
// microcoded controller, a top-of-stack register and an entry memory.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | tdata fields (lowest bit up)                 | Handshake
//  --------+-----+----------------------------------------------+-----------
//  s_axis  | in  | req_type[3:0], push_value[35:4], pad to 40   | tvalid/tready
//  m_axis  | out | top_value[31:0], stack_depth[38:32],         | tvalid/tready
//          |     | status[40:39], pad to 48                     |
//
//  One request at a time. Unknown opcodes go straight to the final step;
//  clear clears; push, pop and not run a check, then their action; add,
//  sub, mul and greater a check, a divider load, then the writeback;
//  divide and modulo add 32 steps of the shared restoring divider.
//  A failed check jumps to the final step. Reset empties the stack; entry
//  memory needs no clearing pass. A finished result sits in the output
//  register while the next request is taken; the controller holds at its
//  final step only while that register is full and not being drained.
//
`default_nettype none

module stack_machine_alu_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // req_type[3:0], push_value[35:4], zeros above
  input  logic [smalu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // top_value[31:0], stack_depth[38:32], status[40:39], zeros above
  output logic [smalu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready
);
  import smalu_pkg::*;

  // Controller state
  logic                   busy_q, busy_d;
  logic [UA_W-1:0]        upc_q, upc_d;
  ucw_t                   ucw;
  logic                   s_acc, fin_go;

  // Request held while it runs
  logic [OP_W-1:0]        op_q;
  logic [DATA_W-1:0]      val_q;

  // Stack: top entry in a register, the rest in memory
  logic [CNT_W-1:0]       depth_q, depth_d;
  logic [DATA_W-1:0]      tos_q, tos_d;
  logic [DATA_W-1:0]      mem [STACK_DEPTH];
  logic [DATA_W-1:0]      rd_q;
  logic                   mem_we, mem_re;
  logic [CNT_W-1:0]       depth_m1, depth_m2;
  logic [PTR_W-1:0]       wr_addr, rd_addr;

  // Status and output register
  logic [ST_W-1:0]        status_q, status_d, chk_status;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic [DATA_W-1:0]      top_out;

  // Datapath
  logic                   is_div, is_empty, is_full, lt_two;
  logic [DATA_W-1:0]      mul_lo, alu_res, quot, rem;
  logic                   div_last;
  div_ctrl_t              div_ctrl;

  assign s_axis_tready = !busy_q;
  assign s_acc         = s_axis_tvalid && !busy_q;
  assign ucw           = ucode_rom(upc_q);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Stack pointers: entry a sits just below the top register
  assign depth_m1 = depth_q - CNT_W'(1);
  assign depth_m2 = depth_q - CNT_W'(2);
  assign wr_addr  = depth_m1[PTR_W-1:0];
  assign rd_addr  = depth_m2[PTR_W-1:0];

  assign is_empty = (depth_q == '0);
  assign is_full  = (depth_q >= CNT_W'(STACK_DEPTH));
  assign lt_two   = (depth_q < CNT_W'(2));
  assign is_div   = (op_q == OP_DIV) || (op_q == OP_MOD);

  // Guard checks, run as the first step of the push, pop, not and binary routines
  always_comb begin
    chk_status = ST_OK;
    case (op_q) inside
      OP_PUSH: begin
        if (is_full) chk_status = ST_OVER;
      end
      OP_POP, OP_NOT: begin
        if (is_empty) chk_status = ST_UNDER;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_GT: begin
        if (lt_two) begin
          chk_status = ST_UNDER;
        end else if (is_div && (tos_q == '0)) begin
          chk_status = ST_DIVZ;
        end
      end
      default: chk_status = ST_OK;
    endcase
  end

  // Binary result: a from memory read data, b from the top register
  assign mul_lo = rd_q * tos_q;

  always_comb begin
    unique case (op_q)
      OP_ADD:  alu_res = rd_q + tos_q;
      OP_SUB:  alu_res = rd_q - tos_q;
      OP_MUL:  alu_res = mul_lo;
      OP_DIV:  alu_res = quot;
      OP_MOD:  alu_res = rem;
      default: alu_res = {{(DATA_W-1){1'b0}}, ($signed(rd_q) > $signed(tos_q))};
    endcase
  end

  assign div_ctrl.init = busy_q && (ucw.act == ACT_DVI);
  assign div_ctrl.step = busy_q && (ucw.act == ACT_DVS);

  smalu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (rd_q),
    .divisor_i  (tos_q),
    .quot_o     (quot),
    .rem_o      (rem),
    .last_o     (div_last)
  );

  // Retire only when the output register is free or being drained
  assign fin_go = busy_q && (ucw.act == ACT_FIN) && (!out_valid_q || m_axis_tready);

  // Sequencer: dispatch on acceptance, then follow the control words
  always_comb begin
    busy_d = busy_q;
    upc_d  = upc_q;
    if (s_acc) begin
      busy_d = 1'b1;
      upc_d  = ucode_entry(s_axis_tdata[OP_W-1:0]);
    end else if (busy_q) begin
      if (ucw.act == ACT_FIN) begin
        if (fin_go) busy_d = 1'b0;
      end else begin
        case (ucw.cond)
          C_GOTO:  upc_d = ucw.target;
          C_ERR:   upc_d = (chk_status != ST_OK) ? ucw.target : upc_q + 1'b1;
          C_NDIV:  upc_d = is_div ? upc_q + 1'b1 : ucw.target;
          C_LOOP:  upc_d = div_last ? upc_q + 1'b1 : ucw.target;
          default: upc_d = upc_q + 1'b1;
        endcase
      end
    end
  end

  // Stack updates per micro-action
  always_comb begin
    depth_d  = depth_q;
    tos_d    = tos_q;
    status_d = status_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    if (s_acc) begin
      status_d = ST_OK;
    end else if (busy_q) begin
      case (ucw.act)
        ACT_CLEAR: depth_d = '0;
        ACT_CHK: begin
          status_d = chk_status;
          mem_re   = 1'b1;
        end
        ACT_PUSH: begin
          // spill the old top into memory unless the stack is empty
          mem_we  = !is_empty;
          tos_d   = val_q;
          depth_d = depth_q + CNT_W'(1);
        end
        ACT_POP: begin
          tos_d   = rd_q;
          depth_d = depth_m1;
        end
        ACT_NOT: tos_d = (tos_q == '0) ? DATA_W'(1) : '0;
        ACT_WB: begin
          tos_d   = alu_res;
          depth_d = depth_m1;
        end
        default: ;
      endcase
    end
  end

  assign top_out = is_empty ? '0 : tos_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_go) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      upc_q       <= UA_FIN;
      depth_q     <= '0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      upc_q       <= upc_d;
      depth_q     <= depth_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
    if (s_acc) begin
      op_q  <= s_axis_tdata[OP_W-1:0];
      val_q <= s_axis_tdata[OP_W +: DATA_W];
    end
    if (fin_go) begin
      out_data_q <= {{(OUT_TDATA_W-DATA_W-DEPTH_OUT_W-ST_W){1'b0}},
                     status_q, DEPTH_OUT_W'(depth_q), top_out};
    end
  end

  // Entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= tos_q;
    if (mem_re) rd_q <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### design/smalu_chk.sv
// ----------------------------------------------------------------------------
// smalu_chk
// Port-level checks on the stack arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module smalu_chk (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [smalu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                 s_axis_tvalid,
  input  logic                                 s_axis_tready,
  input  logic [smalu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready
);
  import smalu_pkg::*;

  logic [DATA_W-1:0]      top_v;
  logic [DEPTH_OUT_W-1:0] depth_v;
  logic [ST_W-1:0]        status_v;

  assign top_v     = m_axis_tdata[DATA_W-1:0];
  assign depth_v   = m_axis_tdata[DATA_W +: DEPTH_OUT_W];
  assign status_v  = m_axis_tdata[DATA_W + DEPTH_OUT_W +: ST_W];

  // Hold a waiting request
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("request changed while waiting");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (depth_v == '0) |-> top_v == '0)
    else $error("empty stack shows a non-zero top");

  a_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status_v == ST_OVER) |-> depth_v == DEPTH_OUT_W'(STACK_DEPTH))
    else $error("overflow reported on a stack that is not full");

  a_under_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status_v == ST_UNDER) |-> depth_v <= DEPTH_OUT_W'(1))
    else $error("underflow reported with two or more entries");

endmodule

bind stack_machine_alu_unit smalu_chk u_smalu_chk (.*);

`default_nettype wire

### tb/tb_stack_machine_alu_unit.sv
// ----------------------------------------------------------------------------
// tb_stack_machine_alu_unit
// Self-checking bench for the stack arithmetic unit. A queue of requests
// (a short directed list, a fill burst and random stack programs) feeds a
// stream driver. A mirror of the stack predicts each result, and the monitor
// compares every returned result with the oldest prediction. Runs in four
// idling phases with one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stack_machine_alu_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import smalu_pkg::*;

  // Idling phases
  localparam int PH_FREE   = 0;  // no idling
  localparam int PH_SEND   = 1;  // sender idles often
  localparam int PH_RECV   = 2;  // receiver stalls often
  localparam int PH_BOTH   = 3;  // both idle now and then

  localparam logic [OP_W-1:0]   OP_UNUSED_FIRST = 4'd10;
  localparam logic [OP_W-1:0]   OP_UNUSED_LAST  = 4'd15;
  localparam logic [DATA_W-1:0] MOST_NEG        = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MOST_POS        = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] MINUS_ONE       = 32'hffff_ffff;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 60;
  localparam int PHASE_ITEMS     = 160;

  typedef struct packed {
    logic [DATA_W-1:0]      top;
    logic [DEPTH_OUT_W-1:0] depth;
    logic [ST_W-1:0]        status;
  } stack_result_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] val;
    int                phase;
  } stack_request_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;

  stack_request_t pending_requests[$];
  stack_result_t  expected_results[$];

  // Mirror of the stack contents
  logic [DATA_W-1:0] stack_mirror [STACK_DEPTH];
  int unsigned       mirror_depth = 0;

  int  gen_depth      = 0;  // rough depth seen by the generator
  int  cur_phase      = PH_FREE;
  logic req_taken     = 1'b0;
  logic rx_hold       = 1'b0;
  int  requests_taken = 0;
  int  results_seen   = 0;
  int  error_count    = 0;
  int  status_count [4] = '{0, 0, 0, 0};

  always #1 clk_i = ~clk_i;

  stack_machine_alu_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_tdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready)
  );

  // Advance the mirror by one request and return the result it must produce.
  function automatic stack_result_t apply_request(input logic [OP_W-1:0] op,
                                                  input logic [DATA_W-1:0] val);
    stack_result_t res;
    logic [DATA_W-1:0] a, b, r;
    longint sa, sb;
    res.status = ST_OK;
    r = '0;
    case (op)
      OP_CLEAR: mirror_depth = 0;
      OP_PUSH: begin
        if (mirror_depth >= STACK_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          stack_mirror[mirror_depth] = val;
          mirror_depth++;
        end
      end
      OP_POP: begin
        if (mirror_depth == 0) res.status = ST_UNDER;
        else mirror_depth--;
      end
      OP_NOT: begin
        if (mirror_depth == 0) begin
          res.status = ST_UNDER;
        end else begin
          stack_mirror[mirror_depth-1] = (stack_mirror[mirror_depth-1] == '0) ? 32'd1 : 32'd0;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_GT: begin
        if (mirror_depth < 2) begin
          res.status = ST_UNDER;
        end else begin
          b = stack_mirror[mirror_depth-1];
          a = stack_mirror[mirror_depth-2];
          if ((op == OP_DIV || op == OP_MOD) && b == '0) begin
            res.status = ST_DIVZ;
          end else begin
            // 64-bit signed divide: truncates toward zero and cannot overflow
            sa = $signed(a);
            sb = $signed(b);
            case (op)
              OP_ADD:  r = a + b;
              OP_SUB:  r = a - b;
              OP_MUL:  r = a * b;
              OP_DIV:  r = 32'(sa / sb);
              OP_MOD:  r = 32'(sa % sb);
              default: r = ($signed(a) > $signed(b)) ? 32'd1 : 32'd0;
            endcase
            mirror_depth--;
            stack_mirror[mirror_depth-1] = r;
          end
        end
      end
      default: ;  // unused opcodes leave the stack alone
    endcase
    res.top   = (mirror_depth > 0) ? stack_mirror[mirror_depth-1] : '0;
    res.depth = DEPTH_OUT_W'(mirror_depth);
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(5))
      0: v = 32'($signed($urandom_range(6)) - 3);  // small, hits zero and minus one
      1: begin
        case ($urandom_range(4))
          0:       v = MOST_NEG;
          1:       v = MOST_POS;
          2:       v = MINUS_ONE;
          3:       v = 32'd1;
          default: v = '0;
        endcase
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic int sender_idle_pct(input int ph);
    return (ph == PH_SEND) ? 73 : (ph == PH_BOTH) ? 7 : 0;
  endfunction

  function automatic int receiver_stall_pct(input int ph);
    return (ph == PH_RECV) ? 73 : (ph == PH_BOTH) ? 7 : 0;
  endfunction

  task automatic add_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                             input int ph);
    stack_request_t rq;
    rq.op    = op;
    rq.val   = val;
    rq.phase = ph;
    pending_requests.push_back(rq);
  endtask

  // Push the stack past full so the overflow path is taken
  task automatic add_fill_burst(input int ph);
    int n;
    n = STACK_DEPTH - gen_depth + $urandom_range(3, 1);
    repeat (n) add_request(OP_PUSH, pick_value(), ph);
    gen_depth = STACK_DEPTH;
  endtask

  // Mostly well-formed stack programs, with clears, unused opcodes and
  // operations on a short stack mixed in.
  task automatic add_random_program(input int count, input int ph);
    int r;
    logic [OP_W-1:0] op;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 2) begin
        add_request(OP_CLEAR, $urandom(), ph);
        gen_depth = 0;
      end else if (r < 4) begin
        add_request(4'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST)), $urandom(), ph);
      end else if (r >= 10 && (gen_depth < 2 || (gen_depth < 48 && r < 55))) begin
        add_request(OP_PUSH, pick_value(), ph);
        if (gen_depth < STACK_DEPTH) gen_depth++;
      end else begin
        op = 4'($urandom_range(OP_GT, OP_POP));
        add_request(op, $urandom(), ph);
        if (op != OP_NOT && gen_depth > 0) gen_depth--;
      end
    end
  endtask

  // Sender: hold the current request until taken, then offer the next or idle.
  always @(negedge clk_i) begin
    stack_request_t rq;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (pending_requests.size() > 0 &&
          $urandom_range(99) >= sender_idle_pct(pending_requests[0].phase)) begin
        rq = pending_requests[0];
        pending_requests.delete(0);
        s_tdata   <= {{(IN_TDATA_W-OP_W-DATA_W){1'b0}}, rq.val, rq.op};
        s_tvalid  <= 1'b1;
        cur_phase <= rq.phase;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random as the phase says, or hold off entirely.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rx_hold && ($urandom_range(99) >= receiver_stall_pct(cur_phase));
    end
  end

  // Hold the output off for a long stretch while requests keep coming, so the
  // result register fills and the input stalls.
  initial begin
    wait (requests_taken >= 40);
    @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  // Monitor: predict on every accepted request, check every accepted result.
  always @(posedge clk_i) begin
    stack_result_t got, want;
    req_taken <= rst_ni && s_tvalid && s_tready;
    if (rst_ni && s_tvalid && s_tready) begin
      expected_results.push_back(apply_request(s_tdata[OP_W-1:0],
                                               s_tdata[OP_W+DATA_W-1:OP_W]));
      requests_taken++;
    end
    if (rst_ni && m_tvalid && m_tready) begin
      got.top    = m_tdata[31:0];
      got.depth  = m_tdata[38:32];
      got.status = m_tdata[40:39];
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: top %0h depth %0d status %0d",
               got.top, got.depth, got.status);
        error_count++;
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        status_count[want.status]++;
        if (got.top !== want.top) begin
          $error("top_value: expected %0h, got %0h", want.top, got.top);
          error_count++;
        end
        if (got.depth !== want.depth) begin
          $error("stack_depth: expected %0d, got %0d", want.depth, got.depth);
          error_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    // Directed: empty-stack underflows, one-entry underflow, most negative
    // divided by minus one, divide and modulo by zero, not on zero, signed
    // greater, multiply by one, truncating divide and modulo of negatives,
    // unused opcodes, clear.
    add_request(OP_POP,   $urandom(), PH_FREE);
    add_request(OP_NOT,   $urandom(), PH_FREE);
    add_request(OP_ADD,   $urandom(), PH_FREE);
    add_request(OP_PUSH,  MOST_NEG,   PH_FREE);
    add_request(OP_SUB,   $urandom(), PH_FREE);
    add_request(OP_PUSH,  MINUS_ONE,  PH_FREE);
    add_request(OP_DIV,   $urandom(), PH_FREE);
    add_request(OP_PUSH,  MINUS_ONE,  PH_FREE);
    add_request(OP_MOD,   $urandom(), PH_FREE);
    add_request(OP_PUSH,  32'd0,      PH_FREE);
    add_request(OP_DIV,   $urandom(), PH_FREE);
    add_request(OP_MOD,   $urandom(), PH_FREE);
    add_request(OP_NOT,   $urandom(), PH_FREE);
    add_request(OP_PUSH,  MOST_POS,   PH_FREE);
    add_request(OP_GT,    $urandom(), PH_FREE);
    add_request(OP_PUSH,  32'hffff_fffb, PH_FREE);
    add_request(OP_GT,    $urandom(), PH_FREE);
    add_request(OP_PUSH,  MOST_POS,   PH_FREE);
    add_request(OP_MUL,   $urandom(), PH_FREE);
    add_request(OP_PUSH,  32'hffff_fff9, PH_FREE);
    add_request(OP_PUSH,  32'd2,      PH_FREE);
    add_request(OP_DIV,   $urandom(), PH_FREE);
    add_request(OP_PUSH,  32'd2,      PH_FREE);
    add_request(OP_MOD,   $urandom(), PH_FREE);
    add_request(OP_UNUSED_FIRST, $urandom(), PH_FREE);
    add_request(OP_UNUSED_LAST,  $urandom(), PH_FREE);
    add_request(OP_CLEAR, $urandom(), PH_FREE);
    gen_depth = 0;

    // Random part, one program per idling phase; the first starts full.
    add_fill_burst(PH_FREE);
    add_random_program(PHASE_ITEMS - STACK_DEPTH, PH_FREE);
    add_random_program(PHASE_ITEMS, PH_SEND);
    add_random_program(PHASE_ITEMS, PH_RECV);
    add_random_program(PHASE_ITEMS, PH_BOTH);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests, %0d results, four idling phases, one output hold-off.",
             requests_taken, results_seen);
    $display("Status counts: ok %0d, underflow %0d, overflow %0d, divide by zero %0d.",
             status_count[ST_OK], status_count[ST_UNDER], status_count[ST_OVER],
             status_count[ST_DIVZ]);
    if (error_count == 0) begin
      $display("tb_stack_machine_alu_unit: done, clean");
    end else begin
      $display("tb_stack_machine_alu_unit: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400_000;
    $display("tb_stack_machine_alu_unit: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
